/* sv/mess_pkg.sv */
// Shared types, constants and the control store for the scanline edge stepper.
// No dependencies; every other source file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package mess_pkg;

  localparam int XW = 10;
  localparam int YW = 6;

  typedef logic [XW-1:0] x_t;
  typedef logic [YW-1:0] y_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DN   = 2'd2
  } dir_t;

  // divider step count: one quotient bit per step
  localparam int CNT_W = $clog2(XW + 1);
  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t DIV_STEPS = CNT_W'(XW);

  // control store
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_SKIP,
    COND_DIV_MORE,
    COND_MORE
  } cond_t;

  localparam int UPC_W       = 2;
  localparam int UCODE_DEPTH = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_ACCEPT = 2'd0;
  localparam upc_t UPC_DIVIDE = 2'd1;
  localparam upc_t UPC_EMIT   = 2'd2;
  localparam upc_t UPC_RETURN = 2'd3;

  typedef struct packed {
    logic  in_ready;
    logic  out_valid;
    logic  div_step;
    wait_t wt;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam uword_t UCODE [UCODE_DEPTH] = '{
    '{in_ready: 1'b1, out_valid: 1'b0, div_step: 1'b0,
      wt: WAIT_IN,   cond: COND_SKIP,     target: UPC_ACCEPT},
    '{in_ready: 1'b0, out_valid: 1'b0, div_step: 1'b1,
      wt: WAIT_NONE, cond: COND_DIV_MORE, target: UPC_DIVIDE},
    '{in_ready: 1'b0, out_valid: 1'b1, div_step: 1'b0,
      wt: WAIT_OUT,  cond: COND_MORE,     target: UPC_EMIT},
    '{in_ready: 1'b0, out_valid: 1'b0, div_step: 1'b0,
      wt: WAIT_NONE, cond: COND_ALWAYS,   target: UPC_ACCEPT}
  };

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic div_step;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic draw;
    logic div_more;
    logic more;
  } status_t;

endpackage

`default_nettype wire

/* sv/mess_ifs.sv */
// Valid/ready channel interfaces for vertex input and edge sample output.
// Depends on mess_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface mess_in_if;
  logic             valid;
  logic             ready;
  mess_pkg::x_t     vertex_x;
  mess_pkg::y_t     vertex_y;
  logic             restart;

  modport source (output valid, output vertex_x, output vertex_y, output restart,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input restart,
                  output ready);
endinterface

interface mess_out_if;
  logic             valid;
  logic             ready;
  mess_pkg::x_t     edge_x;
  mess_pkg::y_t     row_y;
  logic             going_down;
  logic             new_run;
  logic             last;

  modport source (output valid, output edge_x, output row_y, output going_down,
                  output new_run, output last, input ready);
  modport sink   (input valid, input edge_x, input row_y, input going_down,
                  input new_run, input last, output ready);
endinterface

`default_nettype wire

/* sv/mess_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on mess_pkg for the control store and control/status structs.
`timescale 1ns / 1ps
`default_nettype none

module mess_sequencer (
  input  wire                clk,
  input  wire                rst_n,
  input  mess_pkg::status_t  status,
  output mess_pkg::ctrl_t    ctrl
);
  import mess_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   go;
  logic   hit;

  assign uw = UCODE[upc_r];

  always_comb begin
    unique case (uw.wt)
      WAIT_NONE: go = 1'b1;
      WAIT_IN:   go = status.in_fire;
      WAIT_OUT:  go = status.out_fire;
      default:   go = 1'b0;
    endcase
    unique case (uw.cond)
      COND_ALWAYS:   hit = 1'b1;
      COND_SKIP:     hit = !status.draw;
      COND_DIV_MORE: hit = status.div_more;
      COND_MORE:     hit = status.more;
      default:       hit = 1'b0;
    endcase
    if (!go) begin
      upc_nxt = upc_r;
    end else if (hit) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_ACCEPT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl = '{in_ready: uw.in_ready, out_valid: uw.out_valid, div_step: uw.div_step};

  a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.in_ready && ctrl.out_valid))
    else $error("input ready and output valid raised together");

  a_emit_only_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UPC_DIVIDE && upc_nxt != UPC_DIVIDE) |=> (upc_r == UPC_EMIT))
    else $error("division finished without entering emit");

  a_return_to_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == UPC_RETURN) |=> (upc_r == UPC_ACCEPT))
    else $error("return step did not go back to accept");

endmodule

`default_nettype wire

/* sv/mess_divider.sv */
// Restoring divider, one quotient bit per step, for |dx| / dy.
// Depends on mess_pkg for widths and step count.
`timescale 1ns / 1ps
`default_nettype none

module mess_divider (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire           step,
  input  mess_pkg::x_t  dividend,
  input  mess_pkg::y_t  divisor,
  output mess_pkg::x_t  quot,
  output mess_pkg::y_t  rem,
  output logic          more
);
  import mess_pkg::*;

  y_t   pr_r;
  y_t   pr_nxt;
  x_t   qd_r;
  x_t   qd_nxt;
  cnt_t cnt_r;
  cnt_t cnt_nxt;

  logic [YW:0] trial;
  logic [YW:0] diff;
  logic        fits;

  always_comb begin
    trial   = {pr_r, qd_r[XW-1]};
    diff    = trial - {1'b0, divisor};
    fits    = trial >= {1'b0, divisor};
    pr_nxt  = pr_r;
    qd_nxt  = qd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      pr_nxt  = '0;
      qd_nxt  = dividend;
      cnt_nxt = DIV_STEPS;
    end else if (step) begin
      pr_nxt  = fits ? diff[YW-1:0] : trial[YW-1:0];
      qd_nxt  = {qd_r[XW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pr_r <= pr_nxt;
    qd_r <= qd_nxt;
  end

  assign quot = qd_r;
  assign rem  = pr_r;
  assign more = cnt_r != cnt_t'(1);

  a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !start) |-> (cnt_r != '0))
    else $error("divider stepped with no steps left");

endmodule

`default_nettype wire

/* sv/mess_datapath.sv */
// Datapath: current point and direction, edge setup and per-row x stepping.
// Depends on mess_pkg; quotient and remainder come from mess_divider.
`timescale 1ns / 1ps
`default_nettype none

module mess_datapath #(
  parameter int ROWS   = 64,
  parameter int X_SPAN = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  input  mess_pkg::ctrl_t   ctrl,
  input  wire               in_fire,
  input  wire               out_fire,
  input  mess_pkg::x_t      vertex_x,
  input  mess_pkg::y_t      vertex_y,
  input  wire               restart,
  input  mess_pkg::x_t      quot,
  input  mess_pkg::y_t      rem,
  output logic              draw,
  output logic              more,
  output mess_pkg::x_t      dividend,
  output mess_pkg::y_t      divisor,
  output mess_pkg::x_t      edge_x,
  output mess_pkg::y_t      row_y,
  output logic              going_down,
  output logic              new_run,
  output logic              last
);
  import mess_pkg::*;

  localparam logic [16:0] XMAX = 17'(X_SPAN - 1);
  localparam y_t          YMAX = YW'(ROWS - 1);

  x_t   cur_x_r, cur_x_nxt;
  y_t   cur_y_r, cur_y_nxt;
  dir_t dir_r,   dir_nxt;
  x_t   x_r,     x_nxt;
  y_t   row_r,   row_nxt;
  y_t   acc_r,   acc_nxt;
  y_t   left_r,  left_nxt;
  y_t   dy_r,    dy_nxt;
  logic down_r,  down_nxt;
  logic neg_r,   neg_nxt;
  logic fresh_r, fresh_nxt;
  logic first_r, first_nxt;

  x_t          nx;
  y_t          ny;
  logic        up;
  y_t          dy;
  logic        neg;
  dir_t        dir_new;
  logic [YW:0] sum;
  logic        carry;
  x_t          delta;
  x_t          unit;

  always_comb begin
    nx      = (17'(vertex_x) > XMAX) ? XMAX[XW-1:0] : vertex_x;
    ny      = (vertex_y > YMAX) ? YMAX : vertex_y;
    draw    = !restart && (ny != cur_y_r);
    up      = ny > cur_y_r;
    dy      = up ? (ny - cur_y_r) : (cur_y_r - ny);
    dir_new = up ? DIR_UP : DIR_DN;
    neg     = nx <= cur_x_r;
    dividend = neg ? (cur_x_r - nx) : (nx - cur_x_r);

    sum   = {1'b0, acc_r} + {1'b0, rem};
    carry = sum >= {1'b0, dy_r};
    delta = neg_r ? (~quot + 1'b1) : quot;
    unit  = carry ? (neg_r ? '1 : x_t'(1)) : '0;

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    dir_nxt   = dir_r;
    x_nxt     = x_r;
    row_nxt   = row_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    dy_nxt    = dy_r;
    down_nxt  = down_r;
    neg_nxt   = neg_r;
    fresh_nxt = fresh_r;
    first_nxt = first_r;

    if (in_fire) begin
      cur_x_nxt = nx;
      cur_y_nxt = ny;
      if (draw) begin
        dir_nxt   = dir_new;
        x_nxt     = cur_x_r;
        row_nxt   = cur_y_r;
        acc_nxt   = '0;
        left_nxt  = dy;
        dy_nxt    = dy;
        down_nxt  = !up;
        neg_nxt   = neg;
        fresh_nxt = dir_new != dir_r;
        first_nxt = 1'b1;
      end
    end

    if (out_fire) begin
      x_nxt     = x_r + delta + unit;
      acc_nxt   = carry ? (sum[YW-1:0] - dy_r) : sum[YW-1:0];
      row_nxt   = down_r ? (row_r - 1'b1) : (row_r + 1'b1);
      left_nxt  = left_r - 1'b1;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      dir_r   <= DIR_NONE;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    row_r   <= row_nxt;
    acc_r   <= acc_nxt;
    left_r  <= left_nxt;
    dy_r    <= dy_nxt;
    down_r  <= down_nxt;
    neg_r   <= neg_nxt;
    fresh_r <= fresh_nxt;
    first_r <= first_nxt;
  end

  assign divisor    = dy_r;
  assign more       = left_r != y_t'(1);
  assign edge_x     = x_r;
  assign row_y      = row_r;
  assign going_down = down_r;
  assign new_run    = fresh_r && first_r;
  assign last       = left_r == y_t'(1);

  a_acc_below_dy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_valid |-> (acc_r < dy_r))
    else $error("remainder accumulator reached the row count");

  a_samples_left: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_valid |-> (left_r != '0))
    else $error("sample emitted with no rows left");

  a_dir_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && draw) |=> (dir_r == DIR_UP || dir_r == DIR_DN))
    else $error("edge accepted without setting a direction");

endmodule

`default_nettype wire

/* sv/monotone_edge_scanline_stepper.sv */
// Top level of the scanline edge stepper: sequencer, divider and datapath.
// Depends on mess_pkg, mess_ifs, mess_sequencer, mess_divider, mess_datapath.
//
// Vertices arrive one transaction at a time. A restart vertex or one on the
// current row only moves the current point. A vertex on another row draws an
// edge of dy rows and emits dy samples, one per row from the start row toward
// the end row, the end row excluded; the last carries the last flag. Such a
// vertex passes through the accept step, the restoring divider that forms
// |dx| / dy one quotient bit per cycle, the emit step that gives one sample
// per output handshake, and a return to the accept step. A vertex is taken
// only when the previous one is fully done.
`timescale 1ns / 1ps
`default_nettype none

module monotone_edge_scanline_stepper #(
  parameter int ROWS   = 64,
  parameter int X_SPAN = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  mess_in_if.sink      in_ch,
  mess_out_if.source   out_ch
);
  import mess_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    in_fire;
  logic    out_fire;
  logic    draw;
  logic    more;
  logic    div_more;
  x_t      dividend;
  y_t      divisor;
  x_t      quot;
  y_t      rem;

  assign in_fire  = ctrl.in_ready && in_ch.valid;
  assign out_fire = ctrl.out_valid && out_ch.ready;

  assign status = '{in_fire: in_fire, out_fire: out_fire, draw: draw,
                    div_more: div_more, more: more};

  assign in_ch.ready  = ctrl.in_ready;
  assign out_ch.valid = ctrl.out_valid;

  mess_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mess_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && draw),
    .step     (ctrl.div_step),
    .dividend (dividend),
    .divisor  (divisor),
    .quot     (quot),
    .rem      (rem),
    .more     (div_more)
  );

  mess_datapath #(
    .ROWS   (ROWS),
    .X_SPAN (X_SPAN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .out_fire   (out_fire),
    .vertex_x   (in_ch.vertex_x),
    .vertex_y   (in_ch.vertex_y),
    .restart    (in_ch.restart),
    .quot       (quot),
    .rem        (rem),
    .draw       (draw),
    .more       (more),
    .dividend   (dividend),
    .divisor    (divisor),
    .edge_x     (out_ch.edge_x),
    .row_y      (out_ch.row_y),
    .going_down (out_ch.going_down),
    .new_run    (out_ch.new_run),
    .last       (out_ch.last)
  );

endmodule

`default_nettype wire

/* tb/sv/monotone_edge_scanline_stepper_tb.sv */
// Self-checking testbench for monotone_edge_scanline_stepper: vertex driver,
// edge sample monitor, scoreboard and its own edge tracing predictor.
// Depends on mess_pkg, mess_ifs and monotone_edge_scanline_stepper from the RTL.
`timescale 1ns / 1ps

module monotone_edge_scanline_stepper_tb;
  import mess_pkg::*;

  localparam int ROWS       = 64;
  localparam int X_SPAN     = 1024;
  localparam int CLK_PERIOD = 12;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 16;
  localparam int RAND_PER_PHASE = 115;

  typedef struct packed {
    x_t   x;
    y_t   y;
    logic restart;
  } vertex_t;

  typedef struct packed {
    x_t   edge_x;
    y_t   row_y;
    logic going_down;
    logic new_run;
    logic last;
  } sample_t;

  logic clk;
  logic rst_n;

  mess_in_if  in_ch ();
  mess_out_if out_ch ();

  monotone_edge_scanline_stepper #(
    .ROWS   (ROWS),
    .X_SPAN (X_SPAN)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vertex_t vertex_fifo [$];
  sample_t sample_q [$];

  x_t   trace_x;
  y_t   trace_y;
  dir_t trace_dir;
  y_t   gen_y;

  int   in_idle_pct;
  int   out_stall_pct;
  logic in_taken;
  int   vertices_queued;
  int   vertices_taken;
  int   samples_checked;
  int   edges_drawn;
  int   restarts_seen;
  int   flat_moves;
  int   errors;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void trace_vertex(input vertex_t v);
    x_t      nx;
    y_t      ny;
    dir_t    dir;
    int      dy;
    int      dx;
    int      quot;
    int      rem;
    int      step;
    int      acc;
    int      xpos;
    int      row;
    int      rstep;
    logic    fresh;
    sample_t s;
    nx = (int'(v.x) > X_SPAN - 1) ? x_t'(X_SPAN - 1) : v.x;
    ny = (int'(v.y) > ROWS - 1) ? y_t'(ROWS - 1) : v.y;
    if (v.restart || ny == trace_y) begin
      if (v.restart) restarts_seen++;
      else flat_moves++;
      trace_x = nx;
      trace_y = ny;
      return;
    end
    if (ny > trace_y) begin
      dir   = DIR_UP;
      dy    = int'(ny) - int'(trace_y);
      rstep = 1;
    end else begin
      dir   = DIR_DN;
      dy    = int'(trace_y) - int'(ny);
      rstep = -1;
    end
    fresh     = (dir != trace_dir);
    trace_dir = dir;
    dx   = int'(nx) - int'(trace_x);
    quot = dx / dy;
    rem  = dx % dy;
    if (dx > 0) begin
      step = 1;
    end else begin
      step = -1;
      rem  = -rem;
    end
    xpos = int'(trace_x);
    row  = int'(trace_y);
    acc  = 0;
    for (int k = 0; k < dy; k++) begin
      s.edge_x     = x_t'(xpos);
      s.row_y      = y_t'(row);
      s.going_down = (dir == DIR_DN);
      s.new_run    = fresh && (k == 0);
      s.last       = (k == dy - 1);
      sample_q.push_back(s);
      xpos += quot;
      acc  += rem;
      if (acc >= dy) begin
        acc  -= dy;
        xpos += step;
      end
      row += rstep;
    end
    edges_drawn++;
    trace_x = nx;
    trace_y = ny;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // drive inputs on the falling edge
  always @(negedge clk) begin : drive
    vertex_t v;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (vertex_fifo.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          v = vertex_fifo.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.vertex_x <= v.x;
          in_ch.vertex_y <= v.y;
          in_ch.restart  <= v.restart;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // sample both channels on the rising edge; check results before predicting
  always @(posedge clk) begin : monitor
    sample_t want;
    vertex_t v;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sample_q.size() == 0) begin
          $error("unexpected sample: edge_x=%0d row_y=%0d going_down=%0b new_run=%0b last=%0b",
                 out_ch.edge_x, out_ch.row_y, out_ch.going_down, out_ch.new_run,
                 out_ch.last);
          errors++;
        end else begin
          want = sample_q.pop_front();
          check_field("edge_x", want.edge_x, out_ch.edge_x);
          check_field("row_y", want.row_y, out_ch.row_y);
          check_field("going_down", want.going_down, out_ch.going_down);
          check_field("new_run", want.new_run, out_ch.new_run);
          check_field("last", want.last, out_ch.last);
          samples_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        v.x       = in_ch.vertex_x;
        v.y       = in_ch.vertex_y;
        v.restart = in_ch.restart;
        trace_vertex(v);
        vertices_taken++;
      end
      in_taken <= in_ch.valid && in_ch.ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("monotone_edge_scanline_stepper verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_vertex(input int x, input int y, input logic restart);
    vertex_t v;
    v.x       = x_t'(x);
    v.y       = y_t'(y);
    v.restart = restart;
    vertex_fifo.push_back(v);
    gen_y = v.y;
    vertices_queued++;
  endtask

  task automatic add_random_vertices(input int count);
    int roll;
    int y;
    int x;
    int delta;
    int xr;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        y = $urandom_range(ROWS - 1);
      end else if (roll < 16) begin
        y = gen_y;
      end else if (roll < 70) begin
        delta = $urandom_range(8, 1);
        y = $urandom_range(1) ? int'(gen_y) + delta : int'(gen_y) - delta;
        if (y > ROWS - 1) y = int'(gen_y) - delta;
        if (y < 0) y = int'(gen_y) + delta;
      end else if (roll < 90) begin
        y = $urandom_range(ROWS - 1);
      end else begin
        y = $urandom_range(1) ? ROWS - 1 : 0;
      end
      xr = $urandom_range(99);
      x  = (xr < 10) ? 0 : (xr < 20) ? X_SPAN - 1 : $urandom_range(X_SPAN - 1);
      add_vertex(x, y, roll < 8);
    end
  endtask

  task automatic drain();
    while (vertices_taken != vertices_queued || sample_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.vertex_x  = '0;
    in_ch.vertex_y  = '0;
    in_ch.restart   = 1'b0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    trace_x         = '0;
    trace_y         = '0;
    trace_dir       = DIR_NONE;
    gen_y           = '0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    vertices_queued = 0;
    vertices_taken  = 0;
    samples_checked = 0;
    edges_drawn     = 0;
    restarts_seen   = 0;
    flat_moves      = 0;
    errors          = 0;
    idle_cycles     = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_vertex(0, 0, 1'b1);
    add_vertex(X_SPAN - 1, ROWS - 1, 1'b0);
    add_vertex(0, 0, 1'b0);
    add_vertex(0, 0, 1'b0);
    add_vertex(X_SPAN - 1, 0, 1'b0);
    add_vertex(0, 1, 1'b0);
    add_vertex(0, 2, 1'b0);
    add_vertex(700, 33, 1'b1);
    add_vertex(705, 40, 1'b0);
    add_vertex(705, 40, 1'b1);
    add_vertex(100, 10, 1'b0);
    add_vertex(93, 13, 1'b0);
    add_vertex(1000, 14, 1'b0);
    add_vertex(X_SPAN - 1, ROWS - 2, 1'b0);
    add_vertex(X_SPAN - 2, ROWS - 1, 1'b0);
    add_vertex(0, ROWS - 2, 1'b0);
    add_vertex(512, 0, 1'b0);
    add_vertex(513, ROWS - 1, 1'b0);
    add_vertex(X_SPAN - 1, ROWS - 1, 1'b1);
    add_vertex(0, 0, 1'b0);
    add_vertex(341, 3, 1'b0);
    add_random_vertices(RAND_PER_PHASE);
    drain();

    in_idle_pct   = 88;
    out_stall_pct = 0;
    add_random_vertices(RAND_PER_PHASE);
    drain();

    in_idle_pct   = 0;
    out_stall_pct = 88;
    add_random_vertices(RAND_PER_PHASE);
    drain();

    in_idle_pct   = 30;
    out_stall_pct = 30;
    add_random_vertices(RAND_PER_PHASE);
    drain();

    if (sample_q.size() != 0) begin
      $error("%0d expected samples never arrived", sample_q.size());
      errors++;
    end
    $display("covered %0d vertices: %0d edges, %0d restarts, %0d flat moves",
             vertices_taken, edges_drawn, restarts_seen, flat_moves);
    $display("checked %0d edge samples across four input/output pressure phases",
             samples_checked);
    if (errors == 0) begin
      $display("monotone_edge_scanline_stepper verification clean");
    end else begin
      $display("monotone_edge_scanline_stepper verification failed");
    end
    $finish;
  end

endmodule

/* monotone_edge_scanline_stepper.f */
sv/mess_pkg.sv
sv/mess_ifs.sv
sv/mess_sequencer.sv
sv/mess_divider.sv
sv/mess_datapath.sv
sv/monotone_edge_scanline_stepper.sv
tb/sv/monotone_edge_scanline_stepper_tb.sv
